[design/swam_pkg.sv]
// shared types and constants for the sliding window anagram matcher
// holds the letter weight table, payload structs and size defaults; no dependencies
package swam_pkg;

	localparam int MAX_PATTERN_DEF = 256;
	localparam int CODE_W          = 5;
	localparam int WEIGHT_W        = 30;
	localparam int ALPHABET        = 26;

	localparam logic [63:0] HASH_PRIME = 64'd1000000009;
	localparam logic [63:0] HASH_BASE  = 64'd31;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	typedef struct packed {
		logic              op;
		logic              is_start;
		logic [CODE_W-1:0] letter;
	} item_t;

	typedef struct packed {
		logic window_match;
		logic found;
		logic pattern_too_long;
	} result_t;

	typedef logic [WEIGHT_W-1:0] weight_tab_t [2**CODE_W];

	// evaluated at elaboration only; codes past the alphabet weigh zero
	function automatic weight_tab_t build_weights();
		weight_tab_t tab;
		logic [63:0] pw;
		logic [63:0] acc;
		for (int k = 0; k < 2**CODE_W; k++) begin
			tab[k] = '0;
		end
		pw     = 64'd1;
		tab[0] = WEIGHT_W'(1);
		for (int i = 1; i < ALPHABET; i++) begin
			pw     = (pw * HASH_BASE) % HASH_PRIME;
			acc    = (64'(i) * pw + 64'(tab[i-1])) % HASH_PRIME;
			tab[i] = acc[WEIGHT_W-1:0];
		end
		return tab;
	endfunction

	localparam weight_tab_t WEIGHT = build_weights();

endpackage

[design/sliding_window_anagram_matcher_unit.sv]
// sliding window anagram matcher: top level
// depends on swam_pkg for payload structs and the letter weight table
//
// usage:
//  item channel (item_valid / item_stall / item) carries letters tagged as
//  pattern (op 0) or text (op 1); is_start clears the pattern or the text window
//  first. pattern letters sum their weights into the pattern sum; text letters
//  keep a running sum over the last pattern-length letters, read back from a
//  history ram, and report a match when it equals the pattern sum.
//  result channel (result_valid / result_stall / result) returns one beat per
//  item beat, in order.
//  each result is registered in the output register, or in the skid entry if stalled.
//  throughput: one item per cycle while item_stall is low; the history ram is
//  read ahead into a register at the address the next state implies, so the
//  window update is one add, subtract and compare.
//  stall: an output register plus one skid entry; item_stall rises only once
//  the skid entry is full, and a held result does not change.
//  reset: all sums, counts and flags clear and both result entries go empty;
//  the history ram is not cleared, only entries written since the text start
//  are ever used.
module sliding_window_anagram_matcher_unit #(
	parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  swam_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_stall,
	output swam_pkg::result_t result
);
	import swam_pkg::*;

	localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
	localparam int PTR_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int DIFF_W = CNT_W + 1;
	localparam int SUM_W  = WEIGHT_W + CNT_W;

	localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_PATTERN);
	localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(MAX_PATTERN - 1);
	localparam logic [DIFF_W-1:0] MAX_DIFF = DIFF_W'(MAX_PATTERN);

	logic [SUM_W-1:0] pattern_sum_q, window_sum_q;
	logic [CNT_W-1:0] pattern_count_q, text_count_q;
	logic             pattern_overflow_q, found_q;
	logic [PTR_W-1:0] wr_ptr_q;

	logic [CODE_W-1:0] history [MAX_PATTERN];
	logic [CODE_W-1:0] rd_code_q, fwd_code_q;
	logic              fwd_q;

	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;

	logic accept;
	logic is_text;

	logic [SUM_W-1:0]  pattern_sum_d, window_sum_d, ws_base, ps_base;
	logic [CNT_W-1:0]  pattern_count_d, text_count_d, tc_base, pc_base;
	logic              pattern_overflow_d, found_d, ovf_base;
	logic [PTR_W-1:0]  wr_ptr_d, wr_addr;
	logic [PTR_W-1:0]  rd_addr;
	logic [DIFF_W-1:0] rd_diff;
	logic [CODE_W-1:0] old_code;
	logic              drop_oldest, match, wr_en;
	logic [SUM_W-1:0]  w_new, w_old;
	result_t           res_new;

	assign accept     = item_valid && !item_stall;
	assign is_text    = (item.op == OP_TEXT);
	assign item_stall = skid_valid_q;

	assign old_code = fwd_q ? fwd_code_q : rd_code_q;
	assign w_new    = SUM_W'(WEIGHT[item.letter]);
	assign w_old    = SUM_W'(WEIGHT[old_code]);
	assign wr_addr  = item.is_start ? '0 : wr_ptr_q;
	assign wr_en    = accept && is_text;

	always_comb begin
		pattern_sum_d      = pattern_sum_q;
		pattern_count_d    = pattern_count_q;
		pattern_overflow_d = pattern_overflow_q;
		window_sum_d       = window_sum_q;
		text_count_d       = text_count_q;
		wr_ptr_d           = wr_ptr_q;
		found_d            = found_q;
		match              = 1'b0;
		drop_oldest        = 1'b0;
		ps_base            = item.is_start ? '0 : pattern_sum_q;
		pc_base            = item.is_start ? '0 : pattern_count_q;
		ovf_base           = item.is_start ? 1'b0 : pattern_overflow_q;
		ws_base            = item.is_start ? '0 : window_sum_q;
		tc_base            = item.is_start ? '0 : text_count_q;
		if (accept) begin
			if (!is_text) begin
				// a pattern beat always restarts the text side
				window_sum_d = '0;
				text_count_d = '0;
				wr_ptr_d     = '0;
				found_d      = 1'b0;
				if (pc_base >= MAX_CNT) begin
					pattern_sum_d      = ps_base;
					pattern_count_d    = pc_base;
					pattern_overflow_d = 1'b1;
				end else begin
					pattern_sum_d      = ps_base + w_new;
					pattern_count_d    = pc_base + CNT_W'(1);
					pattern_overflow_d = ovf_base;
				end
			end else begin
				drop_oldest  = (pattern_count_q != '0) && (tc_base >= pattern_count_q);
				window_sum_d = ws_base - (drop_oldest ? w_old : '0) + w_new;
				text_count_d = (tc_base < MAX_CNT) ? tc_base + CNT_W'(1) : tc_base;
				wr_ptr_d     = (wr_addr == LAST_PTR) ? '0 : wr_addr + PTR_W'(1);
				match        = !pattern_overflow_q && (pattern_count_q != '0)
					&& (text_count_d >= pattern_count_q)
					&& (window_sum_d == pattern_sum_q);
				found_d      = (item.is_start ? 1'b0 : found_q) || match;
			end
		end
	end

	always_comb begin
		res_new.window_match     = match;
		res_new.found            = found_d;
		res_new.pattern_too_long = pattern_overflow_d;
	end

	// oldest letter of the next window: (next pointer - pattern length) mod depth
	always_comb begin
		rd_diff = DIFF_W'(wr_ptr_d) + MAX_DIFF - DIFF_W'(pattern_count_d);
		if (rd_diff >= MAX_DIFF) begin
			rd_diff = rd_diff - MAX_DIFF;
		end
		rd_addr = rd_diff[PTR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			history[wr_addr] <= item.letter;
		end
		rd_code_q  <= history[rd_addr];
		fwd_code_q <= item.letter;
	end

	// a one-letter pattern reads back the letter written in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_sum_q      <= '0;
			pattern_count_q    <= '0;
			pattern_overflow_q <= 1'b0;
			window_sum_q       <= '0;
			text_count_q       <= '0;
			wr_ptr_q           <= '0;
			found_q            <= 1'b0;
		end else begin
			pattern_sum_q      <= pattern_sum_d;
			pattern_count_q    <= pattern_count_d;
			pattern_overflow_q <= pattern_overflow_d;
			window_sum_q       <= window_sum_d;
			text_count_q       <= text_count_d;
			wr_ptr_q           <= wr_ptr_d;
			found_q            <= found_d;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (out_valid_q && result_stall) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_valid_q && !result_stall) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (out_valid_q && result_stall) begin
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end else if (out_valid_q && !result_stall && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

[design/swam_checker.sv]
// port-level checks for the sliding window anagram matcher
// depends on swam_pkg; bound to sliding_window_anagram_matcher_unit below
module swam_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input swam_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input swam_pkg::result_t result
);
	import swam_pkg::*;

	// a held result beat stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// input pushes back only when a result is already waiting
	a_stall_backed: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("item stall without pending result");

	a_match_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.window_match |-> result.found)
		else $error("match without found flag");

	a_match_not_long: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.window_match |-> !result.pattern_too_long)
		else $error("match reported with overlong pattern");

	// an item beat taken with nothing queued shows up next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !result_valid |=> result_valid)
		else $error("result missing one cycle after item");

endmodule

bind sliding_window_anagram_matcher_unit swam_checker u_swam_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
